/* hdl/dsuf_pkg.sv */
// Package with shared types and constants for the union-find core.
`default_nettype none
package dsuf_pkg;
	localparam int unsigned NODE_W = 8;
	localparam int unsigned RANK_W = 4;
	localparam int unsigned SIZE_W = 9;
	localparam logic [RANK_W-1:0] RANK_MAX = '1;
	localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
	localparam logic ACT_QUERY = 1'b0;
	localparam logic ACT_UNION = 1'b1;
	localparam logic POLICY_RANK = 1'b0;
	localparam logic POLICY_SIZE = 1'b1;
	localparam int unsigned REG_LINK_POLICY = 0;

	typedef struct packed {
		logic                  action;
		logic [NODE_W-1:0]     node_a;
		logic [NODE_W-1:0]     node_b;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0]     root_a;
		logic [NODE_W-1:0]     root_b;
		logic                  same_set;
		logic [NODE_W-1:0]     final_root;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;        // capture request, start walk from node_a
		logic read;        // issue parent read at walk pointer
		logic step;        // advance walk from read data
		logic restart;     // begin compression walk at start node
		logic wr_comp;     // write root to walk node and advance
		logic save_a;      // root of a found, start b
		logic save_b;      // root of b found
		logic rd_meta;     // read rank/size of both roots
		logic link;        // perform the link writes
		logic finish;      // load output register
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic at_root;     // read data equals walk pointer
		logic comp_done;   // compression walk reached the root
		logic same;        // roots equal
		logic unite;       // action is union
	} sts_t;
endpackage
`default_nettype wire

/* hdl/dsuf_if.sv */
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface dsuf_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/disjoint_set_union_find_core.sv */
// Top level of the union-find core: channels, register port and wiring.
// Each request transaction resolves node_a and then node_b to their roots,
// rewriting every node on each walked path to point at its root, and on a
// union links the two roots by rank or by set size (link_policy, register 0
// at address 0). Parent, rank and size live in single-port-read RAMs with a
// registered read, so every hop of a walk is a read state followed by a use
// state (S_RD, then S_FIND), and each compressed node adds a read and a
// write (S_CRD, then S_COMP). A union that links adds the rank and size read
// and the link write. One item is in flight at a time; the response register
// lets the next request enter while the previous response waits. After reset
// a clearing pass over all NODES entries initializes the tables, during which
// no request is taken; register writes are accepted throughout.
`default_nettype none
module disjoint_set_union_find_core #(
	parameter int unsigned NODES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	dsuf_if.sink             req,
	dsuf_if.source           rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [0:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import dsuf_pkg::*;

	logic link_policy_q;
	cmd_t cmd;
	sts_t sts;
	logic clr_done;
	rsp_t rsp_data;
	req_t req_data;

	// Register 0 sits at byte 0; paddr carries only the word-aligned bit.
	assign pready = 1'b1;
	assign prdata = {31'd0, link_policy_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_policy_q <= POLICY_RANK;
		end else if (psel && penable && pwrite && paddr == 1'b0) begin
			link_policy_q <= pwdata[0];
		end
	end

	assign req_data = req.data;
	assign rsp.data = rsp_data;

	dsuf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .clr_done(clr_done),
		.sts(sts), .cmd(cmd));

	dsuf_dp #(.NODES(NODES)) u_dp (
		.clk(clk), .arst_n(arst_n), .link_policy(link_policy_q), .req(req_data),
		.cmd(cmd), .sts(sts), .clr_done(clr_done), .rsp(rsp_data));
endmodule
`default_nettype wire

/* hdl/dsuf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dsuf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hdl/dsuf_ctrl.sv */
// Controller state machine sequencing the find, compress and link steps.
`default_nettype none
module dsuf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire logic          clr_done,
	input  wire dsuf_pkg::sts_t sts,
	output dsuf_pkg::cmd_t     cmd
);
	import dsuf_pkg::*;

	typedef enum logic [10:0] {
		S_CLEAR  = 11'b00000000001,
		S_IDLE   = 11'b00000000010,
		S_RD     = 11'b00000000100,
		S_FIND   = 11'b00000001000,
		S_CRD    = 11'b00000010000,
		S_COMP   = 11'b00000100000,
		S_META   = 11'b00001000000,
		S_METAW  = 11'b00010000000,
		S_LINK   = 11'b00100000000,
		S_DONE   = 11'b01000000000,
		S_WAIT   = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic   second_q;
	logic   out_valid_q;

	assign out_valid = out_valid_q;
	// Output register frees when taken; a new item waits only for the engine.
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_CLEAR: if (clr_done) state_d = S_IDLE;
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.read = 1'b1;
				state_d = S_FIND;
			end
			S_FIND: begin
				if (sts.at_root) begin
					cmd.restart = 1'b1;
					state_d = S_CRD;
				end else begin
					cmd.step = 1'b1;
					state_d = S_RD;
				end
			end
			S_CRD: begin
				if (sts.comp_done) begin
					if (!second_q) begin
						cmd.save_a = 1'b1;
						state_d = S_RD;
					end else begin
						cmd.save_b = 1'b1;
						state_d = S_META;
					end
				end else begin
					cmd.read = 1'b1;
					state_d = S_COMP;
				end
			end
			S_COMP: begin
				cmd.wr_comp = 1'b1;
				state_d = S_CRD;
			end
			S_META: begin
				if (sts.unite && !sts.same) begin
					cmd.rd_meta = 1'b1;
					state_d = S_METAW;
				end else begin
					state_d = S_DONE;
				end
			end
			S_METAW: state_d = S_LINK;
			S_LINK: begin
				cmd.link = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				if (out_ready) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			second_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) second_q <= 1'b0;
			else if (cmd.save_a) second_q <= 1'b1;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

/* hdl/dsuf_dp.sv */
// Datapath: node tables, walk pointers, link logic and result register.
`default_nettype none
module dsuf_dp #(
	parameter int unsigned NODES = 256
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            link_policy,
	input  wire dsuf_pkg::req_t  req,
	input  wire dsuf_pkg::cmd_t  cmd,
	output dsuf_pkg::sts_t       sts,
	output logic                 clr_done,
	output dsuf_pkg::rsp_t       rsp
);
	import dsuf_pkg::*;

	localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int unsigned FW = NODE_W + AW + 1;

	logic          clr_act_q;
	logic [AW:0]   clr_cnt_q;
	logic          action_q;
	logic          fin_b_q;
	logic [AW-1:0] nb_q, start_q, walk_q, root_q, ra_q, rb_q;
	logic [AW-1:0] par_rd, par_ra, par_wa, par_wd;
	logic          par_we;
	logic [RANK_W-1:0] rk_a, rk_b, rk_wd;
	logic [SIZE_W-1:0] sz_a, sz_b, sz_wd;
	logic [AW-1:0] meta_wa;
	logic          rk_we, sz_we;
	logic [SIZE_W:0] sum;
	logic [SIZE_W-1:0] sum_sat;
	logic          a_joins;
	rsp_t          rsp_q;

	// Folds an index onto the node range by shifted compare and subtract.
	function automatic logic [AW-1:0] fold(input logic [NODE_W-1:0] v);
		logic [FW-1:0] w;
		w = FW'(v);
		for (int k = NODE_W - 1; k >= 0; k--) begin
			if (w >= (FW'(NODES) << k)) w = w - (FW'(NODES) << k);
		end
		return AW'(w);
	endfunction

	// Parent table.
	assign par_ra = walk_q;
	always_comb begin
		par_we = 1'b0;
		par_wa = walk_q;
		par_wd = root_q;
		if (clr_act_q) begin
			par_we = 1'b1;
			par_wa = clr_cnt_q[AW-1:0];
			par_wd = clr_cnt_q[AW-1:0];
		end else if (cmd.wr_comp) begin
			par_we = 1'b1;
		end else if (cmd.link) begin
			par_we = 1'b1;
			par_wa = a_joins ? ra_q : rb_q;
			par_wd = a_joins ? rb_q : ra_q;
		end
	end
	dsuf_ram #(.WIDTH(AW), .DEPTH(NODES)) u_par (
		.clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd),
		.raddr(par_ra), .rdata(par_rd));

	// Rank and size tables, two copies each so both roots read at once.
	always_comb begin
		sum = {1'b0, sz_a} + {1'b0, sz_b};
		sum_sat = sum[SIZE_W] ? SIZE_MAX : sum[SIZE_W-1:0];
		if (link_policy == POLICY_RANK) a_joins = (rk_a < rk_b);
		else a_joins = (sz_a < sz_b);
		rk_we = 1'b0;
		sz_we = 1'b0;
		meta_wa = ra_q;
		rk_wd = (rk_a == RANK_MAX) ? rk_a : rk_a + 1'b1;
		sz_wd = sum_sat;
		if (clr_act_q) begin
			rk_we = 1'b1;
			sz_we = 1'b1;
			meta_wa = clr_cnt_q[AW-1:0];
			rk_wd = '0;
			sz_wd = SIZE_W'(1);
		end else if (cmd.link) begin
			if (link_policy == POLICY_RANK) begin
				rk_we = (rk_a == rk_b);
			end else begin
				sz_we = 1'b1;
				meta_wa = a_joins ? rb_q : ra_q;
			end
		end
	end
	dsuf_ram #(.WIDTH(RANK_W), .DEPTH(NODES)) u_rka (
		.clk(clk), .we(rk_we), .waddr(meta_wa), .wdata(rk_wd), .raddr(ra_q), .rdata(rk_a));
	dsuf_ram #(.WIDTH(RANK_W), .DEPTH(NODES)) u_rkb (
		.clk(clk), .we(rk_we), .waddr(meta_wa), .wdata(rk_wd), .raddr(rb_q), .rdata(rk_b));
	dsuf_ram #(.WIDTH(SIZE_W), .DEPTH(NODES)) u_sza (
		.clk(clk), .we(sz_we), .waddr(meta_wa), .wdata(sz_wd), .raddr(ra_q), .rdata(sz_a));
	dsuf_ram #(.WIDTH(SIZE_W), .DEPTH(NODES)) u_szb (
		.clk(clk), .we(sz_we), .waddr(meta_wa), .wdata(sz_wd), .raddr(rb_q), .rdata(sz_b));

	assign clr_done = !clr_act_q;
	assign sts.at_root = (par_rd == walk_q);
	assign sts.comp_done = (walk_q == root_q);
	assign sts.same = (ra_q == rb_q);
	assign sts.unite = (action_q == ACT_UNION);
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_act_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_act_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == (AW+1)'(NODES - 1)) clr_act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= req.action;
			fin_b_q <= 1'b0;
			start_q <= fold(req.node_a);
			walk_q <= fold(req.node_a);
			nb_q <= fold(req.node_b);
		end
		if (cmd.step) walk_q <= par_rd;
		if (cmd.restart) begin
			root_q <= walk_q;
			walk_q <= start_q;
		end
		if (cmd.wr_comp) walk_q <= par_rd;
		if (cmd.save_a) begin
			ra_q <= root_q;
			start_q <= nb_q;
			walk_q <= nb_q;
		end
		if (cmd.save_b) rb_q <= root_q;
		// The result register holds the previous response until finish.
		if (cmd.link) fin_b_q <= a_joins;
		if (cmd.finish) begin
			rsp_q.root_a <= NODE_W'(ra_q);
			rsp_q.root_b <= NODE_W'(rb_q);
			rsp_q.same_set <= (ra_q == rb_q);
			rsp_q.final_root <= fin_b_q ? NODE_W'(rb_q) : NODE_W'(ra_q);
		end
	end
endmodule
`default_nettype wire

/* hdl/dsuf_checker.sv */
// Port-level checker for the union-find core and its bind.
`default_nettype none
module dsuf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic [7:0] root_a,
	input wire logic [7:0] root_b,
	input wire logic same_set,
	input wire logic [7:0] final_root,
	input wire logic pready
);
	a_same: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (same_set == (root_a == root_b))) else $error("same_set mismatch");
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (final_root == root_a || final_root == root_b))
		else $error("final_root not a found root");
	a_noq: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && same_set) |-> final_root == root_a) else $error("link on same set");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready) else $error("accepted twice");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");
endmodule

bind disjoint_set_union_find_core dsuf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .root_a(rsp.data.root_a),
	.root_b(rsp.data.root_b), .same_set(rsp.data.same_set),
	.final_root(rsp.data.final_root), .pready(pready));
`default_nettype wire
